// File: src/fcov_pkg.sv
`timescale 1ns / 1ps

package fcov_pkg;

    localparam int XW = 34;
    localparam int ZW = 28;

    localparam logic signed [19:0] PI_Q13      = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13  = 20'sd51472;
    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic [1:0] CFG_LOOK_GAIN   = 2'd0;
    localparam logic [1:0] CFG_PITCH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_YAW_LIMIT   = 2'd2;

    localparam logic [3:0] PROD_LAST = 4'd13;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_Y,
        ST_MUL_P,
        ST_UPD_P,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Z,
        ST_SUM,
        ST_SQRT,
        ST_AT_Y_GO,
        ST_AT_Y,
        ST_AT_P_GO,
        ST_AT_P,
        ST_SC_Y_GO,
        ST_SC_Y,
        ST_SC_P_GO,
        ST_SC_P,
        ST_PROD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CP_IDLE,
        CP_NORM,
        CP_ITER,
        CP_POST,
        CP_DONE
    } cordic_ph_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_Y,
        OP_MUL_P,
        OP_UPD_P,
        OP_DIFF,
        OP_SQ_X,
        OP_SQ_Z,
        OP_SUM,
        OP_SQRT,
        OP_ATAN_Y,
        OP_YAW_SET,
        OP_ATAN_P,
        OP_PITCH_SET,
        OP_SIN_Y,
        OP_CS_Y,
        OP_SIN_P,
        OP_CS_P,
        OP_PROD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd;
        logic d_zero;
        logic sqrt_last;
        logic cordic_done;
    } dp_stat_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = 28'sd13176795;
            5'd1:    a = 28'sd7778716;
            5'd2:    a = 28'sd4110060;
            5'd3:    a = 28'sd2086331;
            5'd4:    a = 28'sd1047214;
            5'd5:    a = 28'sd524117;
            5'd6:    a = 28'sd262123;
            5'd7:    a = 28'sd131069;
            5'd8:    a = 28'sd65536;
            5'd9:    a = 28'sd32768;
            5'd10:   a = 28'sd16384;
            5'd11:   a = 28'sd8192;
            5'd12:   a = 28'sd4096;
            5'd13:   a = 28'sd2048;
            5'd14:   a = 28'sd1024;
            5'd15:   a = 28'sd512;
            5'd16:   a = 28'sd256;
            5'd17:   a = 28'sd128;
            5'd18:   a = 28'sd64;
            5'd19:   a = 28'sd32;
            5'd20:   a = 28'sd16;
            5'd21:   a = 28'sd8;
            5'd22:   a = 28'sd4;
            5'd23:   a = 28'sd2;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

endpackage

// File: src/fcov_if.sv
`timescale 1ns / 1ps

interface fcov_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [23:0] eye_x;
    logic signed [23:0] eye_y;
    logic signed [23:0] eye_z;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;

    modport source (
        output valid, cmd, offset_x, offset_y, eye_x, eye_y, eye_z,
               target_x, target_y, target_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, offset_x, offset_y, eye_x, eye_y, eye_z,
               target_x, target_y, target_z,
        output ready
    );
endinterface

interface fcov_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [25:0] trans_right;
    logic signed [25:0] trans_up;
    logic signed [25:0] trans_back;

    modport source (
        output valid, right_x, right_y, right_z, up_x, up_y, up_z,
               back_x, back_y, back_z, trans_right, trans_up, trans_back,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, up_x, up_y, up_z,
               back_x, back_y, back_z, trans_right, trans_up, trans_back,
        output ready
    );
endinterface

// File: src/fps_camera_orientation_view.sv
`timescale 1ns / 1ps
// channel   dir   transaction                     fields
// item      in    mouse look or aim command       cmd, offset_x/y, eye_x/y/z, target_x/y/z
// result    out   view matrix for the eye         right/up/back axes, trans_right/up/back
// cfg       in    register write, no read-back    cfg_we, cfg_index, cfg_data
//
// one item at a time; how long mouse look and aim take is set by the shared
// iterative cordic (with its normalizing shifts) and the one-bit-per-cycle
// square root
// reset clears the angles to zero and loads the register defaults
// a result waits in the output register; the next item is taken meanwhile
// and the block stalls at the end of that item until the result is taken

module fps_camera_orientation_view #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    fcov_item_if.sink     item,
    fcov_result_if.source result
);
    import fcov_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    fcov_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .ctl          (ctl)
    );

    fcov_dp #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (item.cmd),
        .offset_x    (item.offset_x),
        .offset_y    (item.offset_y),
        .eye_x       (item.eye_x),
        .eye_y       (item.eye_y),
        .eye_z       (item.eye_z),
        .target_x    (item.target_x),
        .target_y    (item.target_y),
        .target_z    (item.target_z),
        .right_x     (result.right_x),
        .right_y     (result.right_y),
        .right_z     (result.right_z),
        .up_x        (result.up_x),
        .up_y        (result.up_y),
        .up_z        (result.up_z),
        .back_x      (result.back_x),
        .back_y      (result.back_y),
        .back_z      (result.back_z),
        .trans_right (result.trans_right),
        .trans_up    (result.trans_up),
        .trans_back  (result.trans_back)
    );

endmodule

// File: src/fcov_cordic.sv
`timescale 1ns / 1ps

module fcov_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           vec,
    input  logic signed [fcov_pkg::XW-1:0] x0,
    input  logic signed [fcov_pkg::XW-1:0] y0,
    input  logic signed [15:0]             ang,
    output logic                           done,
    output logic signed [fcov_pkg::ZW-1:0] z,
    output logic signed [15:0]             cos_q14,
    output logic signed [15:0]             sin_q14
);
    import fcov_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    cordic_ph_t           phase_reg, phase_next;
    logic [IW-1:0]        i_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 neg_reg;
    logic                 vec_reg;
    logic signed [15:0]   c_reg, s_reg;

    logic signed [ZW-1:0] za, zr;
    logic                 zneg;
    logic                 norm_up;
    logic                 last;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    function automatic logic signed [15:0] q14(input logic signed [XW-1:0] v,
                                               input logic n);
        logic signed [XW-1:0] t;
        logic signed [15:0]   r;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (t < -34'sd16384)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = t[15:0];
        end
        return n ? -r : r;
    endfunction

    always_comb
    begin
        za = $signed({ang[15], ang, 11'd0});
        zr   = za;
        zneg = 1'b0;
        if (za > HALF_PI_Q24)
        begin
            zr   = za - PI_Q24;
            zneg = 1'b1;
        end
        else if (za < -HALF_PI_Q24)
        begin
            zr   = za + PI_Q24;
            zneg = 1'b1;
        end
    end

    assign norm_up = (x_reg < 34'sd536870912) && (x_reg > -34'sd536870912) &&
                     (y_reg < 34'sd536870912) && (y_reg > -34'sd536870912);
    assign last  = (i_reg == IW'(CORDIC_STEPS - 1));
    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign at    = atan_q24(5'(i_reg));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            CP_IDLE:
            begin
                if (start)
                begin
                    if (!vec)
                    begin
                        phase_next = CP_ITER;
                    end
                    else if ((x0 == '0) && (y0 == '0))
                    begin
                        phase_next = CP_DONE;
                    end
                    else
                    begin
                        phase_next = CP_NORM;
                    end
                end
            end
            CP_NORM: phase_next = norm_up ? CP_NORM : CP_ITER;
            CP_ITER: phase_next = last ? CP_POST : CP_ITER;
            CP_POST: phase_next = CP_DONE;
            CP_DONE: phase_next = CP_IDLE;
            default: phase_next = CP_IDLE;
        endcase
    end

    always_comb
    begin
        done = (phase_reg == CP_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= CP_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            CP_IDLE:
            begin
                i_reg <= '0;
                if (start)
                begin
                    vec_reg <= vec;
                end
                if (start && vec)
                begin
                    x_reg   <= x0;
                    y_reg   <= y0;
                    z_reg   <= '0;
                    neg_reg <= 1'b0;
                end
                else if (start)
                begin
                    x_reg   <= GAIN_Q30;
                    y_reg   <= '0;
                    z_reg   <= zr;
                    neg_reg <= zneg;
                end
            end
            CP_NORM:
            begin
                if (norm_up)
                begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
                else if (x_reg < 0)
                begin
                    z_reg <= (y_reg >= 0) ? PI_Q24 : -PI_Q24;
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            CP_ITER:
            begin
                i_reg <= i_reg + 1'b1;
                if (vec_reg ? (y_reg >= 0) : (z_reg < 0))
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
            end
            CP_POST:
            begin
                c_reg <= q14(x_reg, neg_reg);
                s_reg <= q14(y_reg, neg_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign z       = z_reg;
    assign cos_q14 = c_reg;
    assign sin_q14 = s_reg;

endmodule

// File: src/fcov_ctrl.sv
`timescale 1ns / 1ps

module fcov_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  fcov_pkg::dp_stat_t stat,
    output fcov_pkg::dp_cmd_t  ctl
);
    import fcov_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    state_next = item_valid ? ST_DECODE : ST_IDLE;
            ST_DECODE:  state_next = stat.cmd ? ST_DIFF : ST_MUL_Y;
            ST_MUL_Y:   state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_UPD_P;
            ST_UPD_P:   state_next = ST_SC_Y_GO;
            ST_DIFF:    state_next = ST_SQ_X;
            ST_SQ_X:    state_next = stat.d_zero ? ST_SC_Y_GO : ST_SQ_Z;
            ST_SQ_Z:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_SQRT;
            ST_SQRT:    state_next = stat.sqrt_last ? ST_AT_Y_GO : ST_SQRT;
            ST_AT_Y_GO: state_next = ST_AT_Y;
            ST_AT_Y:    state_next = stat.cordic_done ? ST_AT_P_GO : ST_AT_Y;
            ST_AT_P_GO: state_next = ST_AT_P;
            ST_AT_P:    state_next = stat.cordic_done ? ST_SC_Y_GO : ST_AT_P;
            ST_SC_Y_GO: state_next = ST_SC_Y;
            ST_SC_Y:    state_next = stat.cordic_done ? ST_SC_P_GO : ST_SC_Y;
            ST_SC_P_GO: state_next = ST_SC_P;
            ST_SC_P:    state_next = stat.cordic_done ? ST_PROD : ST_SC_P;
            ST_PROD:    state_next = (step_reg == PROD_LAST) ? ST_EMIT : ST_PROD;
            ST_EMIT:    state_next = (!out_valid_reg || result_ready) ? ST_IDLE : ST_EMIT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.op     = OP_NONE;
        ctl.step   = step_reg;
        item_ready = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.op = OP_LOAD;
                end
            end
            ST_MUL_Y:   ctl.op = OP_MUL_Y;
            ST_MUL_P:   ctl.op = OP_MUL_P;
            ST_UPD_P:   ctl.op = OP_UPD_P;
            ST_DIFF:    ctl.op = OP_DIFF;
            ST_SQ_X:    ctl.op = OP_SQ_X;
            ST_SQ_Z:    ctl.op = OP_SQ_Z;
            ST_SUM:     ctl.op = OP_SUM;
            ST_SQRT:    ctl.op = OP_SQRT;
            ST_AT_Y_GO: ctl.op = OP_ATAN_Y;
            ST_AT_Y:    ctl.op = stat.cordic_done ? OP_YAW_SET : OP_NONE;
            ST_AT_P_GO: ctl.op = OP_ATAN_P;
            ST_AT_P:    ctl.op = stat.cordic_done ? OP_PITCH_SET : OP_NONE;
            ST_SC_Y_GO: ctl.op = OP_SIN_Y;
            ST_SC_Y:    ctl.op = stat.cordic_done ? OP_CS_Y : OP_NONE;
            ST_SC_P_GO: ctl.op = OP_SIN_P;
            ST_SC_P:    ctl.op = stat.cordic_done ? OP_CS_P : OP_NONE;
            ST_PROD:    ctl.op = OP_PROD;
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    ctl.op   = OP_EMIT;
                    out_load = 1'b1;
                end
            end
            default:    ctl.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        step_next = (state_reg == ST_PROD) ? step_reg + 4'd1 : 4'd0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: src/fcov_dp.sv
`timescale 1ns / 1ps

module fcov_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fcov_pkg::dp_cmd_t  ctl,
    output fcov_pkg::dp_stat_t stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               cmd,
    input  logic signed [15:0] offset_x,
    input  logic signed [15:0] offset_y,
    input  logic signed [23:0] eye_x,
    input  logic signed [23:0] eye_y,
    input  logic signed [23:0] eye_z,
    input  logic signed [23:0] target_x,
    input  logic signed [23:0] target_y,
    input  logic signed [23:0] target_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z,
    output logic signed [15:0] back_x,
    output logic signed [15:0] back_y,
    output logic signed [15:0] back_z,
    output logic signed [25:0] trans_right,
    output logic signed [25:0] trans_up,
    output logic signed [25:0] trans_back
);
    import fcov_pkg::*;

    localparam logic [4:0] SQRT_TOP = 5'd28;

    logic [15:0]        look_gain_reg;
    logic [13:0]        pitch_limit_reg;
    logic [14:0]        yaw_limit_reg;
    logic signed [15:0] yaw_reg, pitch_reg;

    logic               cmd_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic signed [23:0] ex_reg, ey_reg, ez_reg, tx_reg, ty_reg, tz_reg;
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic signed [49:0] prod_reg, acc_reg;
    logic [57:0]        sqn_reg, sqres_reg;
    logic [4:0]         sqcnt_reg;
    logic signed [15:0] cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [15:0] ax3_reg, ax5_reg, ax6_reg, ax8_reg;
    logic signed [25:0] tr_reg, tu_reg, tb_reg;

    logic signed [24:0]    mul_a, mul_b;
    logic [57:0]           bitv;
    logic [58:0]           trial;
    logic                  sq_ge;
    logic                  cor_start, cor_vec, cor_done;
    logic signed [XW-1:0]  cor_x0, cor_y0;
    logic signed [15:0]    cor_ang, cor_c, cor_s;
    logic signed [ZW-1:0]  cor_z;
    logic signed [ZW:0]    yq;
    logic signed [ZW:0]    yr, pr;
    logic signed [19:0]    yaw_sum, pitch_sum;

    function automatic logic signed [15:0] look_inc(input logic signed [49:0] p);
        logic signed [49:0] r;
        r = (p + 50'sd128) >>> 8;
        if (r > 50'(PI_Q13))
        begin
            return PI_Q13[15:0];
        end
        else if (r < -50'(PI_Q13))
        begin
            return -PI_Q13[15:0];
        end
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] wrap_yaw(input logic signed [19:0] y,
                                                    input logic [14:0] lim);
        logic signed [19:0] v;
        v = y;
        if (y > $signed({5'd0, lim}))
        begin
            v = y - TWO_PI_Q13;
        end
        else if (y < -$signed({5'd0, lim}))
        begin
            v = y + TWO_PI_Q13;
        end
        if (v > 20'sd32767)
        begin
            return 16'sd32767;
        end
        else if (v < -20'sd32768)
        begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] clamp_pitch(input logic signed [19:0] p,
                                                       input logic [13:0] lim);
        if (p > $signed({6'd0, lim}))
        begin
            return $signed({2'd0, lim});
        end
        else if (p < -$signed({6'd0, lim}))
        begin
            return -$signed({2'd0, lim});
        end
        return p[15:0];
    endfunction

    function automatic logic signed [15:0] rnd14(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = (p + 50'sd8192) >>> 14;
        return t[15:0];
    endfunction

    function automatic logic signed [25:0] neg_rnd14(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = -((p + 50'sd8192) >>> 14);
        return t[25:0];
    endfunction

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctl.op)
            OP_MUL_Y:
            begin
                mul_a = -25'(ox_reg);
                mul_b = $signed({9'd0, look_gain_reg});
            end
            OP_MUL_P:
            begin
                mul_a = 25'(oy_reg);
                mul_b = $signed({9'd0, look_gain_reg});
            end
            OP_SQ_X:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            OP_SQ_Z:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            OP_PROD:
            begin
                unique case (ctl.step)
                    4'd0:
                    begin
                        mul_a = 25'(sy_reg);
                        mul_b = 25'(sp_reg);
                    end
                    4'd1:
                    begin
                        mul_a = 25'(cy_reg);
                        mul_b = 25'(sp_reg);
                    end
                    4'd2:
                    begin
                        mul_a = 25'(sy_reg);
                        mul_b = 25'(cp_reg);
                    end
                    4'd3:
                    begin
                        mul_a = 25'(cp_reg);
                        mul_b = 25'(cy_reg);
                    end
                    4'd4:
                    begin
                        mul_a = 25'(cy_reg);
                        mul_b = 25'(ex_reg);
                    end
                    4'd5:
                    begin
                        mul_a = -25'(sy_reg);
                        mul_b = 25'(ez_reg);
                    end
                    4'd6:
                    begin
                        mul_a = 25'(ax3_reg);
                        mul_b = 25'(ex_reg);
                    end
                    4'd7:
                    begin
                        mul_a = 25'(cp_reg);
                        mul_b = 25'(ey_reg);
                    end
                    4'd8:
                    begin
                        mul_a = 25'(ax5_reg);
                        mul_b = 25'(ez_reg);
                    end
                    4'd9:
                    begin
                        mul_a = 25'(ax6_reg);
                        mul_b = 25'(ex_reg);
                    end
                    4'd10:
                    begin
                        mul_a = -25'(sp_reg);
                        mul_b = 25'(ey_reg);
                    end
                    4'd11:
                    begin
                        mul_a = 25'(ax8_reg);
                        mul_b = 25'(ez_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one isqrt digit per cycle
    assign bitv  = 58'd1 << {sqcnt_reg, 1'b0};
    assign trial = {1'b0, sqres_reg} + {1'b0, bitv};
    assign sq_ge = ({1'b0, sqn_reg} >= trial);

    assign cor_start = (ctl.op == OP_ATAN_Y) || (ctl.op == OP_ATAN_P) ||
                       (ctl.op == OP_SIN_Y) || (ctl.op == OP_SIN_P);
    assign cor_vec   = (ctl.op == OP_ATAN_Y) || (ctl.op == OP_ATAN_P);
    assign cor_x0    = (ctl.op == OP_ATAN_P) ? $signed({5'd0, sqres_reg[28:0]})
                                             : XW'(dx_reg);
    assign cor_y0    = (ctl.op == OP_ATAN_P) ? (XW'(dy_reg) <<< 4) : XW'(dz_reg);
    assign cor_ang   = (ctl.op == OP_SIN_P) ? pitch_reg : yaw_reg;

    fcov_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .vec     (cor_vec),
        .x0      (cor_x0),
        .y0      (cor_y0),
        .ang     (cor_ang),
        .done    (cor_done),
        .z       (cor_z),
        .cos_q14 (cor_c),
        .sin_q14 (cor_s)
    );

    assign yq        = -(ZW+1)'(cor_z) - (ZW+1)'(HALF_PI_Q24);
    assign yr        = (yq + 29'sd1024) >>> 11;
    assign pr        = ((ZW+1)'(cor_z) + 29'sd1024) >>> 11;
    assign yaw_sum   = 20'(yaw_reg) + 20'(look_inc(prod_reg));
    assign pitch_sum = 20'(pitch_reg) + 20'(look_inc(prod_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_gain_reg   <= 16'd3660;
            pitch_limit_reg <= 14'd12725;
            yaw_limit_reg   <= 15'd25736;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LOOK_GAIN:   look_gain_reg   <= cfg_data;
                    CFG_PITCH_LIMIT: pitch_limit_reg <= cfg_data[13:0];
                    CFG_YAW_LIMIT:   yaw_limit_reg   <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end
            unique case (ctl.op)
                OP_MUL_P:     yaw_reg   <= wrap_yaw(yaw_sum, yaw_limit_reg);
                OP_UPD_P:     pitch_reg <= clamp_pitch(pitch_sum, pitch_limit_reg);
                OP_YAW_SET:   yaw_reg   <= wrap_yaw(yr[19:0], yaw_limit_reg);
                OP_PITCH_SET: pitch_reg <= clamp_pitch(pr[19:0], pitch_limit_reg);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg <= cmd;
                ox_reg  <= offset_x;
                oy_reg  <= offset_y;
                ex_reg  <= eye_x;
                ey_reg  <= eye_y;
                ez_reg  <= eye_z;
                tx_reg  <= target_x;
                ty_reg  <= target_y;
                tz_reg  <= target_z;
            end
            OP_DIFF:
            begin
                dx_reg <= 25'(tx_reg) - 25'(ex_reg);
                dy_reg <= 25'(ty_reg) - 25'(ey_reg);
                dz_reg <= 25'(tz_reg) - 25'(ez_reg);
            end
            OP_SQ_Z: acc_reg <= prod_reg;
            OP_SUM:
            begin
                sqn_reg   <= {acc_reg + prod_reg, 8'd0};
                sqres_reg <= '0;
                sqcnt_reg <= SQRT_TOP;
            end
            OP_SQRT:
            begin
                sqcnt_reg <= sqcnt_reg - 5'd1;
                if (sq_ge)
                begin
                    sqn_reg   <= sqn_reg - trial[57:0];
                    sqres_reg <= (sqres_reg >> 1) + bitv;
                end
                else
                begin
                    sqres_reg <= sqres_reg >> 1;
                end
            end
            OP_CS_Y:
            begin
                cy_reg <= cor_c;
                sy_reg <= cor_s;
            end
            OP_CS_P:
            begin
                cp_reg <= cor_c;
                sp_reg <= cor_s;
            end
            OP_PROD:
            begin
                case (ctl.step)
                    4'd1:  ax3_reg <= rnd14(prod_reg);
                    4'd2:  ax5_reg <= rnd14(prod_reg);
                    4'd3:  ax6_reg <= rnd14(prod_reg);
                    4'd4:  ax8_reg <= rnd14(prod_reg);
                    4'd5:  acc_reg <= prod_reg;
                    4'd7:
                    begin
                        tr_reg  <= neg_rnd14(acc_reg);
                        acc_reg <= prod_reg;
                    end
                    4'd10:
                    begin
                        tu_reg  <= neg_rnd14(acc_reg);
                        acc_reg <= prod_reg;
                    end
                    4'd13: tb_reg  <= neg_rnd14(acc_reg);
                    4'd6, 4'd8, 4'd9, 4'd11, 4'd12: acc_reg <= acc_reg + prod_reg;
                    default:
                    begin
                    end
                endcase
            end
            OP_EMIT:
            begin
                right_x     <= cy_reg;
                right_y     <= '0;
                right_z     <= -sy_reg;
                up_x        <= ax3_reg;
                up_y        <= cp_reg;
                up_z        <= ax5_reg;
                back_x      <= ax6_reg;
                back_y      <= -sp_reg;
                back_z      <= ax8_reg;
                trans_right <= tr_reg;
                trans_up    <= tu_reg;
                trans_back  <= tb_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.cmd         = cmd_reg;
    assign stat.d_zero      = (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
    assign stat.sqrt_last   = (sqcnt_reg == 5'd0);
    assign stat.cordic_done = cor_done;

endmodule

// File: src/fcov_checker.sv
`timescale 1ns / 1ps

module fcov_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [15:0] right_x,
    input logic signed [15:0] right_y
);

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its right_x value
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(right_x))
        else $error("result changed while stalled");

    // right axis has no vertical part
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (right_y == 16'sd0))
        else $error("right_y not zero");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

endmodule

bind fps_camera_orientation_view fcov_checker u_fcov_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .right_x      (result.right_x),
    .right_y      (result.right_y)
);
